FILE: hdl/mvca_pkg.sv
// ============================================================================
// mvca_pkg: shared types and constants for the mesh volume/centroid block
// Field widths, datapath widths, queue sizing and the result engine states.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package mvca_pkg;

    // Input item layout
    localparam int IN_W       = 12;
    localparam int COORD_BITS = 12;
    localparam int N_FIELDS   = 9;
    localparam int S_TDATA_W  = ((N_FIELDS * IN_W + 7) / 8) * 8;

    // Front datapath widths
    localparam int EDGE_W  = COORD_BITS + 1;
    localparam int SUM1_W  = COORD_BITS + 2;
    localparam int PROD_W  = 2 * COORD_BITS;
    localparam int F2_W    = PROD_W + 3;
    localparam int CROSS_W = 2 * EDGE_W;
    localparam int D_W     = CROSS_W + 1;
    localparam int TV_W    = D_W + SUM1_W;
    localparam int TM_W    = D_W + F2_W;
    localparam int ACC_W   = 64;

    // Result layout
    localparam int VOLUME_W  = 63;
    localparam int CENTRE_W  = 20;
    localparam int M_DATA_W  = VOLUME_W + 3 * CENTRE_W;
    localparam int M_TDATA_W = ((M_DATA_W + 7) / 8) * 8;
    localparam int M_PAD_W   = M_TDATA_W - M_DATA_W;
    localparam int M_TUSER_W = 2;
    localparam int TUSER_ZERO = 0;
    localparam int TUSER_CLIP = 1;

    // Result engine
    localparam int FRAC_BITS = 6;
    localparam int QUOT_W    = CENTRE_W + 1;
    localparam int PRE_SHIFT = QUOT_W - FRAC_BITS;
    localparam int STEP_W    = $clog2(ACC_W);
    localparam logic [QUOT_W-1:0] CENTRE_POS_LIM = QUOT_W'((2 ** (CENTRE_W - 1)) - 1);
    localparam logic [QUOT_W-1:0] CENTRE_NEG_LIM = QUOT_W'(2 ** (CENTRE_W - 1));

    // Volume divide by six: halve, estimate one third by shift-and-add folds,
    // then fix the estimate from the small remainder
    localparam int VSTEP_SEED     = 0;
    localparam int VSTEP_FOLD_END = 4;
    localparam int VSTEP_SUB      = 5;
    localparam int VSTEP_REM      = 6;
    localparam int VSTEP_FIX      = 7;
    localparam int VSTEP_SIGN     = 8;
    localparam int FOLD_SH0       = 4;
    localparam int FIX_REM_W      = 5;
    localparam int FIX_MUL        = 11;
    localparam int FIX_SHIFT      = 5;
    localparam int FIX_PROD_W     = FIX_REM_W + 4;

    // Totals queue
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [ACC_W-1:0] vol;
        logic [ACC_W-1:0] mom_x;
        logic [ACC_W-1:0] mom_y;
        logic [ACC_W-1:0] mom_z;
    } mvca_totals_t;

    typedef struct packed {
        logic         valid;
        mvca_totals_t totals;
    } mvca_push_t;

    typedef struct packed {
        logic full;
        logic empty;
    } mvca_q_status_t;

    typedef enum logic [1:0] {
        AX_X,
        AX_Y,
        AX_Z
    } mvca_axis_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_VOL,
        BK_CSTART,
        BK_CDIV,
        BK_CEND,
        BK_HOLD
    } mvca_back_state_t;

endpackage

`default_nettype wire

FILE: hdl/mesh_volume_centroid_accumulator.sv
// ============================================================================
// mesh_volume_centroid_accumulator: volume and centroid of a triangle mesh
// Streams one triangle per item and emits one result item per mesh.
// ============================================================================
// The block takes one triangle per clock cycle while intake is not stalled.
// Each triangle passes a four-stage product pipeline and is added into four
// 64-bit accumulators; the triangle marked by tlast closes the mesh, and its
// totals move into a two-entry queue while the accumulators start over for
// the next mesh. A result engine drains the queue: a shift-and-add divide by
// six of the volume integral, then one restoring divide per centre axis
// (skipped when the axis saturates); a zero volume skips all divides. Triangle
// intake stalls only when the queue holds two unread meshes and a third closes.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module mesh_volume_centroid_accumulator (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // ax, ay, az, bx, by_coord, bz, cx, cy, cz (12 bits each), zero pad
    input  wire logic [mvca_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    input  wire logic                              s_axis_tlast,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // volume (63), centre_x (20), centre_y (20), centre_z (20), zero pad
    output logic [mvca_pkg::M_TDATA_W-1:0]         m_axis_tdata,
    // volume_zero, centre_clipped
    output logic [mvca_pkg::M_TUSER_W-1:0]         m_axis_tuser
);
    import mvca_pkg::*;

    mvca_push_t       q_push;
    mvca_q_status_t   q_status;
    mvca_totals_t     q_data;
    logic             q_pop;

    mvca_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .q_status      (q_status),
        .q_push        (q_push)
    );

    mvca_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_push   (q_push),
        .q_pop    (q_pop),
        .q_data   (q_data),
        .q_status (q_status)
    );

    mvca_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_status      (q_status),
        .q_data        (q_data),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire

FILE: hdl/mvca_front.sv
// ============================================================================
// mvca_front: triangle intake and mesh integral accumulation
// Four-stage product pipeline feeding 64-bit accumulators; pushes the totals
// of each finished mesh into the queue and clears the accumulators.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module mvca_front (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // ax, ay, az, bx, by_coord, bz, cx, cy, cz (12 bits each), zero pad
    input  wire logic [mvca_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    input  wire logic                              s_axis_tlast,
    input  wire mvca_pkg::mvca_q_status_t          q_status,
    output mvca_pkg::mvca_push_t                   q_push
);
    import mvca_pkg::*;

    logic signed [COORD_BITS-1:0] w0 [3];
    logic signed [COORD_BITS-1:0] w1 [3];
    logic signed [COORD_BITS-1:0] w2 [3];
    logic                         advance;

    logic                       s1_valid_reg, s1_last_reg;
    logic signed [EDGE_W-1:0]   s1_e1_reg [3], s1_e1_next [3];
    logic signed [EDGE_W-1:0]   s1_e2_reg [3], s1_e2_next [3];
    logic signed [SUM1_W-1:0]   s1_f1_reg, s1_f1_next;
    logic signed [PROD_W-1:0]   s1_pr_reg [3][6], s1_pr_next [3][6];

    logic                       s2_valid_reg, s2_last_reg;
    logic signed [CROSS_W-1:0]  s2_cr_reg [6], s2_cr_next [6];
    logic signed [F2_W-1:0]     s2_f2_reg [3], s2_f2_next [3];
    logic signed [SUM1_W-1:0]   s2_f1_reg;

    logic                       s3_valid_reg, s3_last_reg;
    logic signed [D_W-1:0]      s3_d_reg [3], s3_d_next [3];
    logic signed [F2_W-1:0]     s3_f2_reg [3];
    logic signed [SUM1_W-1:0]   s3_f1_reg;

    logic                       s4_valid_reg, s4_last_reg;
    logic signed [TV_W-1:0]     s4_tv_reg, s4_tv_next;
    logic signed [TM_W-1:0]     s4_tm_reg [3], s4_tm_next [3];

    logic [ACC_W-1:0]           acc_vol_reg, acc_vol_next;
    logic [ACC_W-1:0]           acc_m_reg [3], acc_m_next [3];
    logic [ACC_W-1:0]           sum_vol;
    logic [ACC_W-1:0]           sum_m [3];
    logic                       push_now;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            w0[k] = s_axis_tdata[k * IN_W +: COORD_BITS];
            w1[k] = s_axis_tdata[(3 + k) * IN_W +: COORD_BITS];
            w2[k] = s_axis_tdata[(6 + k) * IN_W +: COORD_BITS];
        end
    end

    // hold the whole pipe while a finished mesh cannot enter the queue
    assign advance       = !(s4_valid_reg && s4_last_reg && q_status.full);
    assign s_axis_tready = advance;

    // stage 1: edges, first-order sum, pairwise coordinate products
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            s1_e1_next[k]    = EDGE_W'(w1[k]) - EDGE_W'(w0[k]);
            s1_e2_next[k]    = EDGE_W'(w2[k]) - EDGE_W'(w0[k]);
            s1_pr_next[k][0] = PROD_W'(w0[k]) * PROD_W'(w0[k]);
            s1_pr_next[k][1] = PROD_W'(w1[k]) * PROD_W'(w1[k]);
            s1_pr_next[k][2] = PROD_W'(w2[k]) * PROD_W'(w2[k]);
            s1_pr_next[k][3] = PROD_W'(w0[k]) * PROD_W'(w1[k]);
            s1_pr_next[k][4] = PROD_W'(w0[k]) * PROD_W'(w2[k]);
            s1_pr_next[k][5] = PROD_W'(w1[k]) * PROD_W'(w2[k]);
        end
        s1_f1_next = SUM1_W'(w0[0]) + SUM1_W'(w1[0]) + SUM1_W'(w2[0]);
    end

    // stage 2: cross product terms, second-order sums
    always_comb
    begin
        s2_cr_next[0] = CROSS_W'(s1_e1_reg[1]) * CROSS_W'(s1_e2_reg[2]);
        s2_cr_next[1] = CROSS_W'(s1_e2_reg[1]) * CROSS_W'(s1_e1_reg[2]);
        s2_cr_next[2] = CROSS_W'(s1_e2_reg[0]) * CROSS_W'(s1_e1_reg[2]);
        s2_cr_next[3] = CROSS_W'(s1_e1_reg[0]) * CROSS_W'(s1_e2_reg[2]);
        s2_cr_next[4] = CROSS_W'(s1_e1_reg[0]) * CROSS_W'(s1_e2_reg[1]);
        s2_cr_next[5] = CROSS_W'(s1_e2_reg[0]) * CROSS_W'(s1_e1_reg[1]);
        for (int k = 0; k < 3; k++)
        begin
            s2_f2_next[k] = '0;
            for (int j = 0; j < 6; j++)
            begin
                s2_f2_next[k] = s2_f2_next[k] + F2_W'(s1_pr_reg[k][j]);
            end
        end
    end

    // stage 3: normal vector
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            s3_d_next[k] = D_W'(s2_cr_reg[2 * k]) - D_W'(s2_cr_reg[2 * k + 1]);
        end
    end

    // stage 4: integral terms
    always_comb
    begin
        s4_tv_next = TV_W'(s3_d_reg[0]) * TV_W'(s3_f1_reg);
        for (int k = 0; k < 3; k++)
        begin
            s4_tm_next[k] = TM_W'(s3_d_reg[k]) * TM_W'(s3_f2_reg[k]);
        end
    end

    // accumulate; clear after handing the totals of a mesh to the queue
    always_comb
    begin
        sum_vol  = acc_vol_reg + ACC_W'(s4_tv_reg);
        push_now = s4_valid_reg && s4_last_reg && advance;
        for (int k = 0; k < 3; k++)
        begin
            sum_m[k] = acc_m_reg[k] + ACC_W'(s4_tm_reg[k]);
        end
        acc_vol_next = acc_vol_reg;
        acc_m_next   = acc_m_reg;
        if (push_now)
        begin
            acc_vol_next = '0;
            for (int k = 0; k < 3; k++)
            begin
                acc_m_next[k] = '0;
            end
        end
        else if (s4_valid_reg && advance)
        begin
            acc_vol_next = sum_vol;
            acc_m_next   = sum_m;
        end
        q_push.valid        = push_now;
        q_push.totals.vol   = sum_vol;
        q_push.totals.mom_x = sum_m[0];
        q_push.totals.mom_y = sum_m[1];
        q_push.totals.mom_z = sum_m[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
            s2_last_reg  <= 1'b0;
            s3_last_reg  <= 1'b0;
            s4_last_reg  <= 1'b0;
            acc_vol_reg  <= '0;
            for (int k = 0; k < 3; k++)
            begin
                acc_m_reg[k] <= '0;
            end
        end
        else
        begin
            if (advance)
            begin
                s1_valid_reg <= s_axis_tvalid;
                s2_valid_reg <= s1_valid_reg;
                s3_valid_reg <= s2_valid_reg;
                s4_valid_reg <= s3_valid_reg;
                s1_last_reg  <= s_axis_tlast;
                s2_last_reg  <= s1_last_reg;
                s3_last_reg  <= s2_last_reg;
                s4_last_reg  <= s3_last_reg;
            end
            acc_vol_reg <= acc_vol_next;
            acc_m_reg   <= acc_m_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_e1_reg <= s1_e1_next;
            s1_e2_reg <= s1_e2_next;
            s1_f1_reg <= s1_f1_next;
            s1_pr_reg <= s1_pr_next;
            s2_cr_reg <= s2_cr_next;
            s2_f2_reg <= s2_f2_next;
            s2_f1_reg <= s1_f1_reg;
            s3_d_reg  <= s3_d_next;
            s3_f2_reg <= s2_f2_reg;
            s3_f1_reg <= s2_f1_reg;
            s4_tv_reg <= s4_tv_next;
            s4_tm_reg <= s4_tm_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/mvca_queue.sv
// ============================================================================
// mvca_queue: short queue of finished mesh totals
// Decouples the accumulating front from the dividing result engine.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module mvca_queue (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire mvca_pkg::mvca_push_t     q_push,
    input  wire logic                     q_pop,
    output mvca_pkg::mvca_totals_t        q_data,
    output mvca_pkg::mvca_q_status_t      q_status
);
    import mvca_pkg::*;

    mvca_totals_t         mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]   count_reg, count_next;

    assign q_status.full  = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign q_data         = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (q_push.valid)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({q_push.valid, q_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push.valid)
        begin
            mem[wr_ptr_reg] <= q_push.totals;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/mvca_back.sv
// ============================================================================
// mvca_back: result engine
// Shift-and-add divide of a nonzero volume integral by six, then three
// restoring divides for the centre, with saturation; registered result item.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module mvca_back (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire mvca_pkg::mvca_q_status_t          q_status,
    input  wire mvca_pkg::mvca_totals_t            q_data,
    output logic                                   q_pop,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // volume (63), centre_x (20), centre_y (20), centre_z (20), zero pad
    output logic [mvca_pkg::M_TDATA_W-1:0]         m_axis_tdata,
    // volume_zero, centre_clipped
    output logic [mvca_pkg::M_TUSER_W-1:0]         m_axis_tuser
);
    import mvca_pkg::*;

    mvca_back_state_t       state_reg, state_next;
    mvca_axis_t             axis_reg, axis_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    mvca_totals_t           entry_reg, entry_next;
    logic [ACC_W-1:0]       den_reg, den_next;
    logic [ACC_W-1:0]       vdiv_reg, vdiv_next;
    logic [ACC_W-1:0]       crem_reg, crem_next;
    logic [QUOT_W-1:0]      cdiv_reg, cdiv_next;
    logic                   cneg_reg, cneg_next;
    logic [VOLUME_W-1:0]    vol_res_reg, vol_res_next;
    logic [CENTRE_W-1:0]    cx_reg, cx_next, cy_reg, cy_next, cz_reg, cz_next;
    logic                   zero_res_reg, zero_res_next;
    logic                   clip_res_reg, clip_res_next;
    logic                   m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0]   m_data_reg, m_data_next;
    logic [M_TUSER_W-1:0]   m_user_reg, m_user_next;

    logic                   vol_is_zero;
    logic [ACC_W-1:0]       head_mag;
    logic [ACC_W-1:0]       mom_sel, mom_mag, mom_hi;
    logic                   cen_sat;
    logic [STEP_W-1:0]      vfold_sh;
    logic [ACC_W-1:0]       vfold, vq_neg;
    logic [FIX_PROD_W-1:0]  vfix_prod;
    logic [ACC_W:0]         cr_ext, cr_sub, den_ext;
    logic                   cr_ge;
    logic [QUOT_W-1:0]      cen_lim, cen_mag, cen_signed;
    logic                   cen_over;
    logic                   step_last_vol, step_last_cen;
    logic                   out_free;

    // shared datapath terms
    always_comb
    begin
        vol_is_zero = (q_data.vol == '0);
        head_mag    = q_data.vol[ACC_W-1] ? (ACC_W'(0) - q_data.vol) : q_data.vol;
        case (axis_reg)
            AX_X:    mom_sel = entry_reg.mom_x;
            AX_Y:    mom_sel = entry_reg.mom_y;
            default: mom_sel = entry_reg.mom_z;
        endcase
        mom_mag = mom_sel[ACC_W-1] ? (ACC_W'(0) - mom_sel) : mom_sel;
        mom_hi  = mom_mag >> PRE_SHIFT;
        cen_sat = (mom_hi >= den_reg);

        vfold_sh  = STEP_W'(FOLD_SH0) << (step_reg - 1'b1);
        vfold     = vdiv_reg + (vdiv_reg >> vfold_sh);
        vfix_prod = FIX_PROD_W'(crem_reg[FIX_REM_W-1:0]) * FIX_PROD_W'(FIX_MUL);
        vq_neg    = ACC_W'(0) - vdiv_reg;

        den_ext = {1'b0, den_reg};
        cr_ext  = {crem_reg, cdiv_reg[QUOT_W-1]};
        cr_ge   = (cr_ext >= den_ext);
        cr_sub  = cr_ext - den_ext;

        cen_lim    = cneg_reg ? CENTRE_NEG_LIM : CENTRE_POS_LIM;
        cen_over   = (cdiv_reg > cen_lim);
        cen_mag    = cen_over ? cen_lim : cdiv_reg;
        cen_signed = cneg_reg ? (QUOT_W'(0) - cen_mag) : cen_mag;

        step_last_vol = (step_reg == STEP_W'(VSTEP_SIGN));
        step_last_cen = (step_reg == STEP_W'(QUOT_W - 1));
        out_free      = !m_valid_reg || m_axis_tready;
    end

    always_comb
    begin : next_state
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_status.empty)
                begin
                    state_next = vol_is_zero ? BK_HOLD : BK_VOL;
                end
            end
            BK_VOL:
            begin
                if (step_last_vol)
                begin
                    state_next = BK_CSTART;
                end
            end
            BK_CSTART: state_next = cen_sat ? BK_CEND : BK_CDIV;
            BK_CDIV:
            begin
                if (step_last_cen)
                begin
                    state_next = BK_CEND;
                end
            end
            BK_CEND:   state_next = (axis_reg == AX_Z) ? BK_HOLD : BK_CSTART;
            BK_HOLD:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:   state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin : outputs
        q_pop         = 1'b0;
        axis_next     = axis_reg;
        step_next     = step_reg;
        entry_next    = entry_reg;
        den_next      = den_reg;
        vdiv_next     = vdiv_reg;
        crem_next     = crem_reg;
        cdiv_next     = cdiv_reg;
        cneg_next     = cneg_reg;
        vol_res_next  = vol_res_reg;
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        cz_next       = cz_reg;
        zero_res_next = zero_res_reg;
        clip_res_next = clip_res_reg;
        m_valid_next  = m_valid_reg && !m_axis_tready;
        m_data_next   = m_data_reg;
        m_user_next   = m_user_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_status.empty)
                begin
                    q_pop         = 1'b1;
                    entry_next    = q_data;
                    den_next      = head_mag;
                    step_next     = '0;
                    zero_res_next = vol_is_zero;
                    clip_res_next = 1'b0;
                    vol_res_next  = '0;
                    cx_next       = '0;
                    cy_next       = '0;
                    cz_next       = '0;
                end
            end
            BK_VOL:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(VSTEP_SEED))
                begin
                    // m/4 + m/16 of the halved magnitude m
                    vdiv_next = (den_reg >> 3) + (den_reg >> 5);
                end
                else if (step_reg <= STEP_W'(VSTEP_FOLD_END))
                begin
                    vdiv_next = vfold;
                end
                else if (step_reg == STEP_W'(VSTEP_SUB))
                begin
                    crem_next = (den_reg >> 1) - vdiv_reg;
                end
                else if (step_reg == STEP_W'(VSTEP_REM))
                begin
                    crem_next = crem_reg - (vdiv_reg << 1);
                end
                else if (step_reg == STEP_W'(VSTEP_FIX))
                begin
                    vdiv_next = vdiv_reg + ACC_W'(vfix_prod[FIX_PROD_W-1:FIX_SHIFT]);
                end
                else if (step_last_vol)
                begin
                    vol_res_next = entry_reg.vol[ACC_W-1] ? vq_neg[VOLUME_W-1:0]
                                                          : vdiv_reg[VOLUME_W-1:0];
                    axis_next    = AX_X;
                end
            end
            BK_CSTART:
            begin
                cneg_next = mom_sel[ACC_W-1] ^ entry_reg.vol[ACC_W-1];
                step_next = '0;
                if (cen_sat)
                begin
                    cdiv_next = '1;
                end
                else
                begin
                    crem_next = mom_hi;
                    cdiv_next = {mom_mag[PRE_SHIFT-1:0], FRAC_BITS'(0)};
                end
            end
            BK_CDIV:
            begin
                crem_next = cr_ge ? cr_sub[ACC_W-1:0] : cr_ext[ACC_W-1:0];
                cdiv_next = {cdiv_reg[QUOT_W-2:0], cr_ge};
                step_next = step_reg + 1'b1;
            end
            BK_CEND:
            begin
                clip_res_next = clip_res_reg || cen_over;
                case (axis_reg)
                    AX_X:
                    begin
                        cx_next   = cen_signed[CENTRE_W-1:0];
                        axis_next = AX_Y;
                    end
                    AX_Y:
                    begin
                        cy_next   = cen_signed[CENTRE_W-1:0];
                        axis_next = AX_Z;
                    end
                    default:
                    begin
                        cz_next   = cen_signed[CENTRE_W-1:0];
                        axis_next = AX_X;
                    end
                endcase
            end
            BK_HOLD:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {M_PAD_W'(0), cz_reg, cy_reg, cx_reg, vol_res_reg};
                    m_user_next[TUSER_ZERO] = zero_res_reg;
                    m_user_next[TUSER_CLIP] = clip_res_reg;
                end
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= BK_IDLE;
            axis_reg    <= AX_X;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            axis_reg    <= axis_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg    <= entry_next;
        den_reg      <= den_next;
        vdiv_reg     <= vdiv_next;
        crem_reg     <= crem_next;
        cdiv_reg     <= cdiv_next;
        cneg_reg     <= cneg_next;
        vol_res_reg  <= vol_res_next;
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        cz_reg       <= cz_next;
        zero_res_reg <= zero_res_next;
        clip_res_reg <= clip_res_next;
        m_data_reg   <= m_data_next;
        m_user_reg   <= m_user_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

endmodule

`default_nettype wire

FILE: tb/sv/mesh_volume_centroid_accumulator_checker.sv
// ============================================================================
// mesh_volume_centroid_accumulator_checker: result checker for the mesh block
// Watches both stream channels and keeps its own copy of the four mesh
// integrals. Each accepted triangle is folded into them, and a triangle that
// closes a mesh queues the expected volume, centroid and flags. Each result
// item is compared against the oldest queued mesh result.
// ============================================================================
`timescale 1ns / 1ps

module mesh_volume_centroid_accumulator_checker
    import mvca_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    input  wire logic                   s_axis_tready,
    // ax, ay, az, bx, by_coord, bz, cx, cy, cz (12 bits each), zero pad
    input  wire logic [S_TDATA_W-1:0]   s_axis_tdata,
    input  wire logic                   s_axis_tlast,
    input  wire logic                   m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // volume (63), centre_x (20), centre_y (20), centre_z (20), zero pad
    input  wire logic [M_TDATA_W-1:0]   m_axis_tdata,
    // volume_zero, centre_clipped
    input  wire logic [M_TUSER_W-1:0]   m_axis_tuser,
    output int                          fail_count,
    output int                          pending
);

    typedef struct packed {
        logic [VOLUME_W-1:0] volume;
        logic [CENTRE_W-1:0] centre_x;
        logic [CENTRE_W-1:0] centre_y;
        logic [CENTRE_W-1:0] centre_z;
        logic                volume_zero;
        logic                centre_clipped;
    } mesh_result_t;

    logic [ACC_W-1:0] vol_sum   = '0;
    logic [ACC_W-1:0] mom_x_sum = '0;
    logic [ACC_W-1:0] mom_y_sum = '0;
    logic [ACC_W-1:0] mom_z_sum = '0;
    mesh_result_t     mesh_results [$];

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    function automatic logic [ACC_W-1:0] abs64(input logic [ACC_W-1:0] v);
        return v[ACC_W-1] ? -v : v;
    endfunction

    function automatic longint face_sum2(input longint a, input longint b, input longint c);
        return a * a + b * b + c * c + a * b + a * c + b * c;
    endfunction

    function automatic logic [CENTRE_W-1:0] centroid_axis(input logic [ACC_W-1:0] num,
                                                          input logic [ACC_W-1:0] den,
                                                          inout logic clip);
        logic             neg;
        logic [ACC_W-1:0] n;
        logic [ACC_W-1:0] d;
        logic [ACC_W-1:0] q;
        logic [ACC_W-1:0] r;
        logic [ACC_W-1:0] lim;
        int               i;
        neg = num[ACC_W-1] ^ den[ACC_W-1];
        n   = abs64(num);
        d   = abs64(den);
        lim = neg ? 64'd524288 : 64'd524287;
        q   = n / d;
        r   = n % d;
        if (q >= 64'd16384)
        begin
            clip = 1'b1;
            q    = lim;
        end
        else
        begin
            for (i = 0; i < FRAC_BITS; i++)
            begin
                r = r << 1;
                q = q << 1;
                if (r >= d)
                begin
                    r    = r - d;
                    q[0] = 1'b1;
                end
            end
            if (q > lim)
            begin
                clip = 1'b1;
                q    = lim;
            end
        end
        q = neg ? -q : q;
        return q[CENTRE_W-1:0];
    endfunction

    // fold one triangle in; queue the mesh result when it closes the mesh
    function automatic void absorb_triangle(input logic [S_TDATA_W-1:0] data,
                                            input logic closes);
        longint       w [N_FIELDS];
        longint       ex1, ey1, ez1, ex2, ey2, ez2, d0, d1, d2;
        logic [ACC_W-1:0] mag;
        logic [ACC_W-1:0] vol;
        mesh_result_t res;
        int           k;
        for (k = 0; k < N_FIELDS; k++)
            w[k] = longint'($signed(data[k*IN_W +: IN_W]));
        ex1 = w[3] - w[0];
        ey1 = w[4] - w[1];
        ez1 = w[5] - w[2];
        ex2 = w[6] - w[0];
        ey2 = w[7] - w[1];
        ez2 = w[8] - w[2];
        d0  = ey1 * ez2 - ey2 * ez1;
        d1  = ex2 * ez1 - ex1 * ez2;
        d2  = ex1 * ey2 - ex2 * ey1;
        vol_sum   = vol_sum   + ACC_W'(d0 * (w[0] + w[3] + w[6]));
        mom_x_sum = mom_x_sum + ACC_W'(d0 * face_sum2(w[0], w[3], w[6]));
        mom_y_sum = mom_y_sum + ACC_W'(d1 * face_sum2(w[1], w[4], w[7]));
        mom_z_sum = mom_z_sum + ACC_W'(d2 * face_sum2(w[2], w[5], w[8]));
        if (!closes)
            return;
        res = '0;
        if (vol_sum == '0)
            res.volume_zero = 1'b1;
        else
        begin
            mag = abs64(vol_sum) / 64'd6;
            vol = vol_sum[ACC_W-1] ? -mag : mag;
            res.volume   = vol[VOLUME_W-1:0];
            res.centre_x = centroid_axis(mom_x_sum, vol_sum, res.centre_clipped);
            res.centre_y = centroid_axis(mom_y_sum, vol_sum, res.centre_clipped);
            res.centre_z = centroid_axis(mom_z_sum, vol_sum, res.centre_clipped);
        end
        mesh_results.push_back(res);
        vol_sum   = '0;
        mom_x_sum = '0;
        mom_y_sum = '0;
        mom_z_sum = '0;
    endfunction

    always @(posedge clk)
    begin : watch
        mesh_result_t got;
        mesh_result_t want;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                absorb_triangle(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.volume         = m_axis_tdata[VOLUME_W-1:0];
                got.centre_x       = m_axis_tdata[VOLUME_W +: CENTRE_W];
                got.centre_y       = m_axis_tdata[VOLUME_W + CENTRE_W +: CENTRE_W];
                got.centre_z       = m_axis_tdata[VOLUME_W + 2 * CENTRE_W +: CENTRE_W];
                got.volume_zero    = m_axis_tuser[TUSER_ZERO];
                got.centre_clipped = m_axis_tuser[TUSER_CLIP];
                if (mesh_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: result item with no mesh closed: vol=%h c=%h/%h/%h f=%b%b",
                                 $realtime, got.volume, got.centre_x, got.centre_y,
                                 got.centre_z, got.volume_zero, got.centre_clipped);
                end
                else
                begin
                    want = mesh_results.pop_front();
                    if (got.volume !== want.volume || got.centre_x !== want.centre_x ||
                        got.centre_y !== want.centre_y || got.centre_z !== want.centre_z ||
                        got.volume_zero !== want.volume_zero ||
                        got.centre_clipped !== want.centre_clipped)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("%0t: mesh result mismatch", $realtime);
                            $display("  expected vol=%h c=%h/%h/%h zero=%b clip=%b",
                                     want.volume, want.centre_x, want.centre_y,
                                     want.centre_z, want.volume_zero, want.centre_clipped);
                            $display("  actual   vol=%h c=%h/%h/%h zero=%b clip=%b",
                                     got.volume, got.centre_x, got.centre_y,
                                     got.centre_z, got.volume_zero, got.centre_clipped);
                        end
                    end
                end
            end
            pending = mesh_results.size();
        end
    end

endmodule

FILE: tb/sv/mesh_volume_centroid_accumulator_tb.sv
// ============================================================================
// mesh_volume_centroid_accumulator_tb: stimulus and verdict for the mesh block
// Streams directed meshes (extreme corners, unit and inverted tetrahedra,
// flat and cancelling meshes) and then random closed tetrahedral meshes mixed
// with random triangle soup, under random source gaps and sink stalls. The
// checker beside the block predicts and compares every result item.
// ============================================================================
`timescale 1ns / 1ps

module mesh_volume_centroid_accumulator_tb;
    import mvca_pkg::*;

    localparam int RANDOM_ITEMS = 1800;
    localparam int QUIET_ITEMS  = 250;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int SETTLE       = 400;

    typedef struct packed {
        logic signed [IN_W-1:0] x;
        logic signed [IN_W-1:0] y;
        logic signed [IN_W-1:0] z;
    } point_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic                 s_axis_tlast = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [M_TUSER_W-1:0] m_axis_tuser;
    int                   fail_count;
    int                   pending;
    int                   items_sent = 0;
    int                   gap_pct = 0;
    int                   stall_pct = 0;
    int                   cycles = 0;

    mesh_volume_centroid_accumulator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    mesh_volume_centroid_accumulator_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("mesh_volume_centroid_accumulator verification failed");
            $finish;
        end
    end

    // sink: random stall bursts
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    function automatic point_t pt(input int x, input int y, input int z);
        point_t p;
        p.x = IN_W'(x);
        p.y = IN_W'(y);
        p.z = IN_W'(z);
        return p;
    endfunction

    // span 0: anywhere on the grid; otherwise within span of centre
    function automatic point_t rand_point(input point_t centre, input int span);
        if (span == 0)
            return pt($urandom_range(0, 4095), $urandom_range(0, 4095),
                      $urandom_range(0, 4095));
        return pt(int'(centre.x) + int'($urandom_range(0, 2 * span)) - span,
                  int'(centre.y) + int'($urandom_range(0, 2 * span)) - span,
                  int'(centre.z) + int'($urandom_range(0, 2 * span)) - span);
    endfunction

    task automatic send_facet(input point_t a, input point_t b, input point_t c,
                              input logic last);
        logic took;
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        s_axis_tdata  <= S_TDATA_W'({c.z, c.y, c.x, b.z, b.y, b.x, a.z, a.y, a.x});
        s_axis_tlast  <= last;
        s_axis_tvalid <= 1'b1;
        do
        begin
            @(negedge clk);
            took = s_axis_tready;
            @(posedge clk);
        end
        while (!took);
        items_sent++;
    endtask

    task automatic send_tetra(input point_t p0, input point_t p1, input point_t p2,
                              input point_t p3, input logic flip, input logic close);
        send_facet(p0, flip ? p1 : p2, flip ? p2 : p1, 1'b0);
        send_facet(p0, flip ? p3 : p1, flip ? p1 : p3, 1'b0);
        send_facet(p0, flip ? p2 : p3, flip ? p3 : p2, 1'b0);
        send_facet(p1, flip ? p3 : p2, flip ? p2 : p3, close);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        @(posedge clk);
    endtask

    task automatic send_random_mesh();
        point_t centre;
        point_t a;
        point_t b;
        point_t c;
        int     kind;
        int     span;
        int     n;
        int     k;
        kind   = $urandom_range(0, 99);
        centre = pt(int'($urandom_range(0, 3600)) - 1800, int'($urandom_range(0, 3600)) - 1800,
                    int'($urandom_range(0, 3600)) - 1800);
        case ($urandom_range(0, 2))
            0: span = 0;
            1: span = $urandom_range(1, 8);
            default: span = $urandom_range(9, 200);
        endcase
        if (kind < 55)
        begin
            n = $urandom_range(1, 3);
            for (k = 0; k < n; k++)
                send_tetra(rand_point(centre, span), rand_point(centre, span),
                           rand_point(centre, span), rand_point(centre, span),
                           $urandom_range(0, 1), k == n - 1);
        end
        else if (kind < 75)
        begin
            n = $urandom_range(1, 8);
            for (k = 0; k < n; k++)
                send_facet(rand_point(centre, 0), rand_point(centre, 0),
                           rand_point(centre, 0), k == n - 1);
        end
        else if (kind < 85)
        begin
            a = rand_point(centre, span);
            b = rand_point(centre, span);
            c = rand_point(centre, span);
            if ($urandom_range(0, 1))
            begin
                send_facet(a, b, c, 1'b0);
                send_facet(a, c, b, 1'b1);
            end
            else
                send_facet(a, b, a, 1'b1);
        end
        else
        begin
            send_tetra(rand_point(centre, span), rand_point(centre, span),
                       rand_point(centre, span), rand_point(centre, span),
                       $urandom_range(0, 1), 1'b0);
            n = $urandom_range(1, 3);
            for (k = 0; k < n; k++)
                send_facet(rand_point(centre, span), rand_point(centre, span),
                           rand_point(centre, span), k == n - 1);
        end
    endtask

    initial
    begin : stimulus
        int target;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // degenerate triangles at the grid corners
        send_facet(pt(-2048, -2048, -2048), pt(-2048, -2048, -2048),
                   pt(-2048, -2048, -2048), 1'b1);
        send_facet(pt(2047, 2047, 2047), pt(2047, 2047, 2047), pt(2047, 2047, 2047), 1'b1);
        // unit tetrahedron: nonzero integral whose volume truncates to zero
        send_tetra(pt(0, 0, 0), pt(1, 0, 0), pt(0, 1, 0), pt(0, 0, 1), 1'b0, 1'b1);
        // full-grid tetrahedron, both orientations
        send_tetra(pt(-2048, -2048, -2048), pt(2047, -2048, -2048), pt(-2048, 2047, -2048),
                   pt(-2048, -2048, 2047), 1'b0, 1'b1);
        send_tetra(pt(-2048, -2048, -2048), pt(2047, -2048, -2048), pt(-2048, 2047, -2048),
                   pt(-2048, -2048, 2047), 1'b1, 1'b1);
        // cancelling pair: zero integral from nonzero triangles
        send_facet(pt(2047, -2048, 0), pt(-2048, 2047, 2047), pt(0, 0, -2048), 1'b0);
        send_facet(pt(2047, -2048, 0), pt(0, 0, -2048), pt(-2048, 2047, 2047), 1'b1);
        // open triangles with extreme coordinates, likely to saturate
        send_facet(pt(-2048, 2047, -2048), pt(2047, -2048, 2047), pt(2047, 2047, -2048), 1'b0);
        send_facet(pt(-1, 1, 0), pt(1, -1, 1), pt(2047, 2047, 2047), 1'b0);
        send_facet(pt(-2048, 1, 2), pt(3, -2048, 5), pt(7, 11, -2048), 1'b1);

        drain_results();

        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target)
        begin
            if (target - items_sent < QUIET_ITEMS)
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            else if ($urandom_range(0, 9) == 0)
            begin
                case ($urandom_range(0, 2))
                    0: gap_pct = 0;
                    1: gap_pct = 5;
                    default: gap_pct = 25;
                endcase
                case ($urandom_range(0, 2))
                    0: stall_pct = 0;
                    1: stall_pct = 5;
                    default: stall_pct = 25;
                endcase
            end
            send_random_mesh();
            if ($urandom_range(0, 49) == 0)
                drain_results();
        end
        s_axis_tvalid <= 1'b0;

        do
            @(negedge clk);
        while (pending != 0);
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0)
            $display("mesh_volume_centroid_accumulator verification clean");
        else
            $display("mesh_volume_centroid_accumulator verification failed");
        $finish;
    end

endmodule
